/* design/rwl_pkg.sv */
`default_nettype none
package rwl_pkg;

  // Field widths of the request and response words
  localparam int ACT_W    = 3;
  localparam int ID_W     = 16;
  localparam int STAT_W   = 3;
  localparam int RDCNT_W  = 2;

  // Default sizing
  localparam int FILE_SLOTS_DEF = 16;
  localparam int PROG_SLOTS_DEF = 16;
  localparam int MAX_HOLD_DEF   = 2;
  localparam int ID_BITS_DEF    = 16;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CREATE_FILE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CREATE_PROG = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ACQ_READ    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACQ_WRITE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REL_READ    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REL_WRITE   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_REL_ALL     = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NONE        = 3'd7;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP       = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOTHING   = 3'd5;

endpackage
`default_nettype wire

/* design/rwl_if.sv */
`default_nettype none
interface rwl_req_if;
  import rwl_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ID_W-1:0]   file_id;
  logic [ID_W-1:0]   program_id;

  modport source (output valid, action, file_id, program_id, input ready);
  modport sink   (input valid, action, file_id, program_id, output ready);
endinterface

interface rwl_rsp_if;
  import rwl_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    released_file;
  logic [RDCNT_W-1:0] readers_now;
  logic               writers_now;
  logic               last_result;

  modport source (output valid, status, released_file, readers_now, writers_now,
                  last_result, input ready);
  modport sink   (input valid, status, released_file, readers_now, writers_now,
                  last_result, output ready);
endinterface
`default_nettype wire

/* design/rwl_ram.sv */
`default_nettype none
module rwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/reader_writer_lock_table.sv */
`default_nettype none
// Channel | Dir | Word fields
// req     | in  | action[2:0], file_id[15:0], program_id[15:0]
// rsp     | out | status[2:0], released_file[15:0], readers_now[1:0],
//         |     | writers_now, last_result
//
// One request word is worked at a time; req.ready is high only while idle.
// A search reads and compares the live entries one at a time, up to the first hit.
// Per word: idle, the searches, then a do step and emit for create and acquire;
// a release checks the stack, pops each hold (stack read, file search, update), then emits.
// Reset (rst, synchronous) clears fill counts and sequencer.
// A stalled response word holds in the output register; emit waits for it.
module reader_writer_lock_table #(
  parameter int FILE_SLOTS = rwl_pkg::FILE_SLOTS_DEF,
  parameter int PROG_SLOTS = rwl_pkg::PROG_SLOTS_DEF,
  parameter int MAX_HOLD   = rwl_pkg::MAX_HOLD_DEF,
  parameter int ID_BITS    = rwl_pkg::ID_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rwl_req_if.sink   req,
  rwl_rsp_if.source rsp
);
  import rwl_pkg::*;

  // Keys compare in their low ID_BITS bits, capped by the field width
  localparam int KEY_W     = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int FIDX_W    = $clog2(FILE_SLOTS);
  localparam int PIDX_W    = $clog2(PROG_SLOTS);
  localparam int FCNT_W    = $clog2(FILE_SLOTS + 1);
  localparam int PCNT_W    = $clog2(PROG_SLOTS + 1);
  localparam int SCAN_W    = (FCNT_W > PCNT_W) ? FCNT_W : PCNT_W;
  localparam int DEP_W     = $clog2(MAX_HOLD + 1);
  localparam int STK_DEPTH = 2 * PROG_SLOTS * MAX_HOLD;
  localparam int STK_AW    = $clog2(STK_DEPTH);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [DEP_W-1:0] rd;
    logic             wr;
  } fent_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [DEP_W-1:0] rdep;
    logic [DEP_W-1:0] wdep;
  } pent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FS_RD, S_FS_CMP, S_PS_RD, S_PS_CMP, S_CF_DO, S_CP_DO,
    S_ACQ_DO, S_POP, S_POP_RD, S_POP_UPD, S_EMIT
  } state_t;

  state_t state;

  // Working registers of the current request
  logic [ACT_W-1:0]  act;
  logic              kind;       // 0 read stack, 1 write stack
  logic [KEY_W-1:0]  skey;       // file key under search
  logic [KEY_W-1:0]  pkey;
  logic [SCAN_W-1:0] scan;
  logic              ffound, pfound;
  logic [FIDX_W-1:0] fidx;
  logic [PIDX_W-1:0] pidx;
  fent_t             fent;
  pent_t             pent;
  logic [FCNT_W-1:0] files_used;
  logic [PCNT_W-1:0] progs_used;

  // Pending response record
  logic [STAT_W-1:0] res_st;
  logic [KEY_W-1:0]  res_fid;
  logic [DEP_W-1:0]  res_rd;
  logic              res_wr;

  // Output register
  logic               out_valid;
  logic [STAT_W-1:0]  out_st;
  logic [ID_W-1:0]    out_fid;
  logic [RDCNT_W-1:0] out_rd;
  logic               out_wr;
  logic               out_last;

  // Memory ports
  logic              fm_we;
  logic [FIDX_W-1:0] fm_waddr;
  fent_t             fm_wdata, fm_rdata;
  logic              pm_we;
  logic [PIDX_W-1:0] pm_waddr;
  pent_t             pm_wdata, pm_rdata;
  logic              sm_we;
  logic [STK_AW-1:0] sm_addr;
  logic [KEY_W-1:0]  sm_rdata;

  logic [DEP_W-1:0] cur_dep, dep_m1, stk_dep;
  logic             acq_refuse, acq_full, acq_ok, emit_free;
  fent_t            fent_acq, fent_rel;
  pent_t            pent_acq, pent_pop;
  logic [31:0]      rd_wide;

  rwl_ram #(.WIDTH($bits(fent_t)), .DEPTH(FILE_SLOTS)) u_file_mem (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(scan[FIDX_W-1:0]), .rdata(fm_rdata)
  );

  rwl_ram #(.WIDTH($bits(pent_t)), .DEPTH(PROG_SLOTS)) u_prog_mem (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(scan[PIDX_W-1:0]), .rdata(pm_rdata)
  );

  rwl_ram #(.WIDTH(KEY_W), .DEPTH(STK_DEPTH)) u_stack_mem (
    .clk(clk), .we(sm_we), .waddr(sm_addr), .wdata(skey),
    .raddr(sm_addr), .rdata(sm_rdata)
  );

  // Where to go once a file search ends
  function automatic state_t file_next(logic [ACT_W-1:0] a);
    state_t n;
    unique case (a) inside
      ACT_CREATE_FILE:             n = S_CF_DO;
      ACT_ACQ_READ, ACT_ACQ_WRITE: n = S_PS_RD;
      default:                     n = S_POP_UPD;
    endcase
    return n;
  endfunction

  // Where to go once a program search ends
  function automatic state_t prog_next(logic [ACT_W-1:0] a, logic hit);
    state_t n;
    unique case (a) inside
      ACT_CREATE_PROG:             n = S_CP_DO;
      ACT_ACQ_READ, ACT_ACQ_WRITE: n = S_ACQ_DO;
      default:                     n = hit ? S_POP : S_EMIT;
    endcase
    return n;
  endfunction

  always_comb begin
    cur_dep    = kind ? pent.wdep : pent.rdep;
    dep_m1     = cur_dep - DEP_W'(1);
    acq_refuse = kind ? (fent.wr || fent.rd != '0)
                      : (fent.wr || fent.rd >= DEP_W'(MAX_HOLD));
    acq_full   = cur_dep >= DEP_W'(MAX_HOLD);
    acq_ok     = ffound && pfound && !acq_refuse && !acq_full;

    fent_acq = fent;
    pent_acq = pent;
    pent_pop = pent;
    fent_rel = fent;
    if (kind) begin
      fent_acq.wr   = 1'b1;
      pent_acq.wdep = cur_dep + DEP_W'(1);
      pent_pop.wdep = dep_m1;
      fent_rel.wr   = 1'b0;
    end else begin
      fent_acq.rd   = fent.rd + DEP_W'(1);
      pent_acq.rdep = cur_dep + DEP_W'(1);
      pent_pop.rdep = dep_m1;
      if (fent.rd != '0) begin
        fent_rel.rd = fent.rd - DEP_W'(1);
      end
    end

    stk_dep = (state == S_ACQ_DO) ? cur_dep : dep_m1;
    sm_addr = STK_AW'(((32'(kind) * PROG_SLOTS) + 32'(pidx)) * MAX_HOLD + 32'(stk_dep));

    fm_we    = 1'b0;
    fm_waddr = fidx;
    fm_wdata = fent_acq;
    pm_we    = 1'b0;
    pm_waddr = pidx;
    pm_wdata = pent_acq;
    sm_we    = 1'b0;

    unique case (state)
      S_CF_DO: begin
        fm_waddr = files_used[FIDX_W-1:0];
        fm_wdata = '{key: skey, rd: '0, wr: 1'b0};
        fm_we    = !ffound && files_used != FCNT_W'(FILE_SLOTS);
      end
      S_CP_DO: begin
        pm_waddr = progs_used[PIDX_W-1:0];
        pm_wdata = '{key: pkey, rdep: '0, wdep: '0};
        pm_we    = !pfound && progs_used != PCNT_W'(PROG_SLOTS);
      end
      S_ACQ_DO: begin
        fm_we = acq_ok;
        pm_we = acq_ok;
        sm_we = acq_ok;
      end
      S_POP: begin
        pm_wdata = pent_pop;
        pm_we    = cur_dep != '0;
      end
      S_POP_UPD: begin
        fm_wdata = fent_rel;
        fm_we    = ffound;
      end
      default: ;
    endcase
  end

  assign emit_free = !out_valid || rsp.ready;
  assign rd_wide   = 32'(res_rd);
  assign req.ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      files_used <= '0;
      progs_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            act     <= req.action;
            skey    <= req.file_id[KEY_W-1:0];
            pkey    <= req.program_id[KEY_W-1:0];
            kind    <= (req.action == ACT_ACQ_WRITE) || (req.action == ACT_REL_WRITE);
            scan    <= '0;
            ffound  <= 1'b0;
            pfound  <= 1'b0;
            res_st  <= ST_NOTHING;
            res_fid <= '0;
            res_rd  <= '0;
            res_wr  <= 1'b0;
            unique case (req.action) inside
              ACT_CREATE_FILE, ACT_ACQ_READ, ACT_ACQ_WRITE: state <= S_FS_RD;
              ACT_CREATE_PROG, ACT_REL_READ, ACT_REL_WRITE,
              ACT_REL_ALL:                                  state <= S_PS_RD;
              default:                                      state <= S_IDLE;
            endcase
          end
        end
        S_FS_RD: begin
          if (scan == SCAN_W'(files_used)) begin
            ffound <= 1'b0;
            scan   <= '0;
            state  <= file_next(act);
          end else begin
            state <= S_FS_CMP;
          end
        end
        S_FS_CMP: begin
          if (fm_rdata.key == skey) begin
            ffound <= 1'b1;
            fidx   <= scan[FIDX_W-1:0];
            fent   <= fm_rdata;
            scan   <= '0;
            state  <= file_next(act);
          end else begin
            scan  <= scan + SCAN_W'(1);
            state <= S_FS_RD;
          end
        end
        S_PS_RD: begin
          if (scan == SCAN_W'(progs_used)) begin
            pfound <= 1'b0;
            if (act[2]) begin
              res_st <= ST_NOT_FOUND;
            end
            state <= prog_next(act, 1'b0);
          end else begin
            state <= S_PS_CMP;
          end
        end
        S_PS_CMP: begin
          if (pm_rdata.key == pkey) begin
            pfound <= 1'b1;
            pidx   <= scan[PIDX_W-1:0];
            pent   <= pm_rdata;
            state  <= prog_next(act, 1'b1);
          end else begin
            scan  <= scan + SCAN_W'(1);
            state <= S_PS_RD;
          end
        end
        S_CF_DO: begin
          if (ffound) begin
            res_st <= ST_DUP;
          end else if (files_used == FCNT_W'(FILE_SLOTS)) begin
            res_st <= ST_FULL;
          end else begin
            res_st     <= ST_OK;
            files_used <= files_used + FCNT_W'(1);
          end
          state <= S_EMIT;
        end
        S_CP_DO: begin
          if (pfound) begin
            res_st <= ST_DUP;
          end else if (progs_used == PCNT_W'(PROG_SLOTS)) begin
            res_st <= ST_FULL;
          end else begin
            res_st     <= ST_OK;
            progs_used <= progs_used + PCNT_W'(1);
          end
          state <= S_EMIT;
        end
        S_ACQ_DO: begin
          // Counts show the file as found, or as updated on a grant
          res_rd <= ffound ? fent.rd : '0;
          res_wr <= ffound ? fent.wr : 1'b0;
          if (!ffound || !pfound) begin
            res_st <= ST_NOT_FOUND;
          end else if (acq_refuse) begin
            res_st <= ST_REFUSED;
          end else if (acq_full) begin
            res_st <= ST_FULL;
          end else begin
            res_st  <= ST_OK;
            res_fid <= skey;
            res_rd  <= fent_acq.rd;
            res_wr  <= fent_acq.wr;
          end
          state <= S_EMIT;
        end
        S_POP: begin
          if (cur_dep == '0) begin
            state <= S_EMIT;
          end else begin
            pent  <= pent_pop;
            state <= S_POP_RD;
          end
        end
        S_POP_RD: begin
          skey  <= sm_rdata;
          scan  <= '0;
          state <= S_FS_RD;
        end
        S_POP_UPD: begin
          if (ffound) begin
            res_st  <= ST_OK;
            res_fid <= skey;
            res_rd  <= fent_rel.rd;
            res_wr  <= fent_rel.wr;
          end else begin
            res_st  <= ST_NOT_FOUND;
            res_fid <= '0;
            res_rd  <= '0;
            res_wr  <= 1'b0;
          end
          // Release-all drains the whole stack before answering
          state <= (act == ACT_REL_ALL) ? S_POP : S_EMIT;
        end
        S_EMIT: begin
          if (emit_free) begin
            out_valid <= 1'b1;
            out_st    <= res_st;
            out_fid   <= ID_W'(res_fid);
            out_rd    <= rd_wide[RDCNT_W-1:0];
            out_wr    <= res_wr;
            out_last  <= !(act == ACT_REL_ALL && !kind);
            if (act == ACT_REL_ALL && !kind) begin
              // Advance to the write stack
              kind <= 1'b1;
              if (pfound) begin
                res_st  <= ST_NOTHING;
                res_fid <= '0;
                res_rd  <= '0;
                res_wr  <= 1'b0;
                state   <= S_POP;
              end else begin
                state <= S_EMIT;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_st;
  assign rsp.released_file = out_fid;
  assign rsp.readers_now   = out_rd;
  assign rsp.writers_now   = out_wr;
  assign rsp.last_result   = out_last;

endmodule
`default_nettype wire

/* design/rwl_chk.sv */
`default_nettype none
module rwl_chk (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [2:0]           in_action,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           out_status,
  input wire logic [15:0]          out_file,
  input wire logic [1:0]           out_readers,
  input wire logic                 out_writers,
  input wire logic                 out_last
);
  import rwl_pkg::*;

  // Ready drops in the cycle after a real request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action != ACT_NONE |=> !in_ready)
    else $error("ready stayed high after a request was taken");

  // A stalled response word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_file) && $stable(out_last))
    else $error("response word changed while stalled");

  // Only a successful grant or release names a file
  a_fid_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_file == '0)
    else $error("file named on a failed response");

  // A file never shows readers and a writer together
  a_rw_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_writers && out_readers != '0))
    else $error("readers and writer reported together");

  // The first word of a release-all pair leaves the sequencer busy
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken between the two words of a release-all");

endmodule

bind reader_writer_lock_table rwl_chk u_rwl_chk (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready), .in_action(req.action),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_status(rsp.status),
  .out_file(rsp.released_file), .out_readers(rsp.readers_now),
  .out_writers(rsp.writers_now), .out_last(rsp.last_result)
);
`default_nettype wire

/* tb/sv/rwl_tb_if.sv */
`timescale 1ns / 100ps
// The channel interfaces come with the block (rwl_req_if, rwl_rsp_if); this
// file only carries the word types that the testbench passes around.
package rwl_tb_pkg;
  import rwl_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  file_id;
    logic [ID_W-1:0]  program_id;
  } lock_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    released_file;
    logic [RDCNT_W-1:0] readers_now;
    logic               writers_now;
    logic               last_result;
  } lock_rsp_t;
endpackage

/* tb/sv/reader_writer_lock_table_tb.sv */
`timescale 1ns / 100ps
module reader_writer_lock_table_tb;
  import rwl_pkg::*;
  import rwl_tb_pkg::*;

  localparam int NF = 16;
  localparam int NP = 16;
  localparam int MH = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  rwl_req_if req ();
  rwl_rsp_if rsp ();

  reader_writer_lock_table u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Lock table shadow: live entries only, same layout as the block
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0] sh_file_id [NF];
  int              sh_readers [NF];
  int              sh_writer  [NF];
  int              sh_files;
  logic [ID_W-1:0] sh_prog_id [NP];
  logic [ID_W-1:0] sh_rstack  [NP][MH];
  logic [ID_W-1:0] sh_wstack  [NP][MH];
  int              sh_rdepth  [NP];
  int              sh_wdepth  [NP];
  int              sh_progs;

  lock_req_t pending_words[$];
  lock_rsp_t expected_rsp[$];

  function automatic int lookup_file(logic [ID_W-1:0] id);
    for (int i = 0; i < sh_files; i++) if (sh_file_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int lookup_prog(logic [ID_W-1:0] id);
    for (int i = 0; i < sh_progs; i++) if (sh_prog_id[i] == id) return i;
    return -1;
  endfunction

  function automatic lock_rsp_t make_rsp(logic [STAT_W-1:0] st, logic [ID_W-1:0] fid,
                                         int f, bit last);
    lock_rsp_t r;
    r.status        = st;
    r.released_file = fid;
    r.readers_now   = (f >= 0) ? sh_readers[f][RDCNT_W-1:0] : '0;
    r.writers_now   = (f >= 0) ? sh_writer[f][0] : 1'b0;
    r.last_result   = last;
    return r;
  endfunction

  // Pop the top hold of one stack and drop the file's count.
  task automatic pop_hold(int p, bit wr, output logic [STAT_W-1:0] st,
                          output logic [ID_W-1:0] fid, output int f);
    logic [ID_W-1:0] id;
    fid = '0;
    f   = -1;
    if ((wr ? sh_wdepth[p] : sh_rdepth[p]) == 0) begin
      st = ST_NOTHING;
      return;
    end
    if (wr) begin
      sh_wdepth[p]--;
      id = sh_wstack[p][sh_wdepth[p]];
    end else begin
      sh_rdepth[p]--;
      id = sh_rstack[p][sh_rdepth[p]];
    end
    f = lookup_file(id);
    if (f < 0) begin
      st = ST_NOT_FOUND;
      return;
    end
    if (wr) sh_writer[f] = 0;
    else if (sh_readers[f] > 0) sh_readers[f]--;
    fid = id;
    st  = ST_OK;
  endtask

  task automatic drain_stack(int p, bit wr, bit last);
    logic [STAT_W-1:0] st;
    logic [ID_W-1:0]   fid;
    int                f;
    logic [STAT_W-1:0] last_st = ST_NOTHING;
    logic [ID_W-1:0]   last_fid = '0;
    int                last_f = -1;
    while ((wr ? sh_wdepth[p] : sh_rdepth[p]) != 0) begin
      pop_hold(p, wr, st, fid, f);
      last_st = st; last_fid = fid; last_f = f;
    end
    expected_rsp.push_back(make_rsp(last_st, last_fid, last_f, last));
  endtask

  // Advance the shadow table by one accepted request word.
  task automatic predict_lock_step(lock_req_t w);
    int f, p;
    logic [STAT_W-1:0] st;
    logic [ID_W-1:0]   fid;
    case (w.action)
      ACT_CREATE_FILE: begin
        if (lookup_file(w.file_id) >= 0)
          expected_rsp.push_back(make_rsp(ST_DUP, '0, -1, 1'b1));
        else if (sh_files >= NF) expected_rsp.push_back(make_rsp(ST_FULL, '0, -1, 1'b1));
        else begin
          sh_file_id[sh_files] = w.file_id;
          sh_readers[sh_files] = 0;
          sh_writer[sh_files]  = 0;
          sh_files++;
          expected_rsp.push_back(make_rsp(ST_OK, '0, sh_files - 1, 1'b1));
        end
      end
      ACT_CREATE_PROG: begin
        if (lookup_prog(w.program_id) >= 0)
          expected_rsp.push_back(make_rsp(ST_DUP, '0, -1, 1'b1));
        else if (sh_progs >= NP) expected_rsp.push_back(make_rsp(ST_FULL, '0, -1, 1'b1));
        else begin
          sh_prog_id[sh_progs] = w.program_id;
          sh_rdepth[sh_progs]  = 0;
          sh_wdepth[sh_progs]  = 0;
          sh_progs++;
          expected_rsp.push_back(make_rsp(ST_OK, '0, -1, 1'b1));
        end
      end
      ACT_ACQ_READ, ACT_ACQ_WRITE: begin
        f = lookup_file(w.file_id);
        p = lookup_prog(w.program_id);
        if (f < 0 || p < 0) expected_rsp.push_back(make_rsp(ST_NOT_FOUND, '0, f, 1'b1));
        else if (w.action == ACT_ACQ_READ) begin
          if (sh_writer[f] != 0 || sh_readers[f] >= MH)
            expected_rsp.push_back(make_rsp(ST_REFUSED, '0, f, 1'b1));
          else if (sh_rdepth[p] >= MH)
            expected_rsp.push_back(make_rsp(ST_FULL, '0, f, 1'b1));
          else begin
            sh_readers[f]++;
            sh_rstack[p][sh_rdepth[p]] = w.file_id;
            sh_rdepth[p]++;
            expected_rsp.push_back(make_rsp(ST_OK, w.file_id, f, 1'b1));
          end
        end else begin
          if (sh_writer[f] != 0 || sh_readers[f] != 0)
            expected_rsp.push_back(make_rsp(ST_REFUSED, '0, f, 1'b1));
          else if (sh_wdepth[p] >= MH)
            expected_rsp.push_back(make_rsp(ST_FULL, '0, f, 1'b1));
          else begin
            sh_writer[f] = 1;
            sh_wstack[p][sh_wdepth[p]] = w.file_id;
            sh_wdepth[p]++;
            expected_rsp.push_back(make_rsp(ST_OK, w.file_id, f, 1'b1));
          end
        end
      end
      ACT_REL_READ, ACT_REL_WRITE: begin
        p = lookup_prog(w.program_id);
        if (p < 0) expected_rsp.push_back(make_rsp(ST_NOT_FOUND, '0, -1, 1'b1));
        else begin
          pop_hold(p, w.action == ACT_REL_WRITE, st, fid, f);
          expected_rsp.push_back(make_rsp(st, fid, f, 1'b1));
        end
      end
      ACT_REL_ALL: begin
        p = lookup_prog(w.program_id);
        if (p < 0) begin
          expected_rsp.push_back(make_rsp(ST_NOT_FOUND, '0, -1, 1'b0));
          expected_rsp.push_back(make_rsp(ST_NOT_FOUND, '0, -1, 1'b1));
        end else begin
          drain_stack(p, 1'b0, 1'b0);
          drain_stack(p, 1'b1, 1'b1);
        end
      end
      default: ;  // unused code: no response word
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold the word until accepted, idle at random between words
  // ---------------------------------------------------------------------------
  lock_req_t cur_word;

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) predict_lock_step(cur_word);
      if (!req.valid || req.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word       = pending_words.pop_front();
          req.valid      <= 1'b1;
          req.action     <= cur_word.action;
          req.file_id    <= cur_word.file_id;
          req.program_id <= cur_word.program_id;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted response word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lock_rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected word, status", 32'(rsp.status), 32'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.released_file !== want.released_file)
            report_mismatch("released_file", 32'(rsp.released_file),
                            32'(want.released_file));
          if (rsp.readers_now !== want.readers_now)
            report_mismatch("readers_now", 32'(rsp.readers_now), 32'(want.readers_now));
          if (rsp.writers_now !== want.writers_now)
            report_mismatch("writers_now", 32'(rsp.writers_now), 32'(want.writers_now));
          if (rsp.last_result !== want.last_result)
            report_mismatch("last_result", 32'(rsp.last_result), 32'(want.last_result));
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Small ID pools so creates collide, acquires find entries and stacks fill.
  logic [ID_W-1:0] file_pool[8];
  logic [ID_W-1:0] prog_pool[8];

  function automatic lock_req_t mk(logic [ACT_W-1:0] a, logic [ID_W-1:0] fi,
                                   logic [ID_W-1:0] pi);
    lock_req_t w;
    w.action = a; w.file_id = fi; w.program_id = pi;
    return w;
  endfunction

  function automatic logic [ID_W-1:0] pick_id(ref logic [ID_W-1:0] pool[8]);
    if ($urandom_range(19) == 0) return ID_W'($urandom);
    return pool[$urandom_range(7)];
  endfunction

  function automatic lock_req_t random_word();
    int r;
    logic [ACT_W-1:0] a;
    r = $urandom_range(99);
    if (r < 6) a = ACT_CREATE_FILE;
    else if (r < 12) a = ACT_CREATE_PROG;
    else if (r < 40) a = ACT_ACQ_READ;
    else if (r < 62) a = ACT_ACQ_WRITE;
    else if (r < 78) a = ACT_REL_READ;
    else if (r < 92) a = ACT_REL_WRITE;
    else if (r < 98) a = ACT_REL_ALL;
    else a = ACT_NONE;
    return mk(a, pick_id(file_pool), pick_id(prog_pool));
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || req.valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    req.valid = 1'b0; req.action = ACT_NONE; req.file_id = '0; req.program_id = '0;
    rsp.ready = 1'b0;
    sh_files = 0; sh_progs = 0;
    for (int i = 0; i < 8; i++) begin
      file_pool[i] = ID_W'($urandom);
      prog_pool[i] = ID_W'($urandom);
    end
    file_pool[0] = '0; file_pool[1] = '1;
    prog_pool[0] = '0; prog_pool[1] = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme IDs, every action, the busy, full, empty and stale cases.
    pending_words.push_back(mk(ACT_REL_READ, 16'h0, 16'h0));      // unknown program
    pending_words.push_back(mk(ACT_REL_ALL, 16'h0, 16'h0));       // unknown, two words
    pending_words.push_back(mk(ACT_CREATE_FILE, 16'h0, 16'h0));
    pending_words.push_back(mk(ACT_CREATE_FILE, 16'hFFFF, 16'h0));
    pending_words.push_back(mk(ACT_CREATE_FILE, 16'hFFFF, 16'h0)); // duplicate
    pending_words.push_back(mk(ACT_CREATE_PROG, 16'h0, 16'hFFFF));
    pending_words.push_back(mk(ACT_CREATE_PROG, 16'h0, 16'h0));
    pending_words.push_back(mk(ACT_CREATE_PROG, 16'h0, 16'h0));    // duplicate
    pending_words.push_back(mk(ACT_ACQ_READ, 16'h1234, 16'h0));    // file not found
    pending_words.push_back(mk(ACT_REL_READ, 16'h0, 16'h0));       // nothing held
    pending_words.push_back(mk(ACT_ACQ_READ, 16'hFFFF, 16'h0));
    pending_words.push_back(mk(ACT_ACQ_READ, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(mk(ACT_ACQ_READ, 16'hFFFF, 16'h0));    // readers at max
    pending_words.push_back(mk(ACT_ACQ_WRITE, 16'hFFFF, 16'h0));   // readers present
    pending_words.push_back(mk(ACT_ACQ_WRITE, 16'h0, 16'h0));
    pending_words.push_back(mk(ACT_ACQ_READ, 16'h0, 16'hFFFF));    // writer present
    pending_words.push_back(mk(ACT_ACQ_READ, 16'hFFFF, 16'hFFFF)); // refused at max
    pending_words.push_back(mk(ACT_REL_WRITE, 16'h0, 16'h0));
    pending_words.push_back(mk(ACT_ACQ_READ, 16'h0, 16'h0));       // granted; read stack now full
    pending_words.push_back(mk(ACT_NONE, 16'hFFFF, 16'hFFFF));     // ignored
    pending_words.push_back(mk(ACT_ACQ_WRITE, 16'h0, 16'hFFFF));
    pending_words.push_back(mk(ACT_REL_ALL, 16'h0, 16'hFFFF));
    pending_words.push_back(mk(ACT_REL_ALL, 16'h0, 16'hFFFF));     // both stacks empty
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 11 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 11 : 0;
      for (int i = 0; i < 500; i++) pending_words.push_back(random_word());
      // Fill the tables early in the first phase so acquires go deep.
      if (ph == 0) begin
        for (int i = 0; i < 8; i++) begin
          pending_words.push_front(mk(ACT_CREATE_PROG, '0, prog_pool[i]));
          pending_words.push_front(mk(ACT_CREATE_FILE, file_pool[i], '0));
        end
      end
      wait_drained();
    end

    // Fill both tables with fresh IDs, then overflow them.
    for (int i = 0; i < 18; i++) begin
      pending_words.push_back(mk(ACT_CREATE_FILE, ID_W'(16'hA000 + i), '0));
      pending_words.push_back(mk(ACT_CREATE_PROG, '0, ID_W'(16'hA000 + i)));
    end
    wait_drained();

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Allow ample margin over the slowest case.
  initial begin
    #(20ns * 2000000);
    $display("FAIL");
    $finish;
  end

endmodule
